@@ rtl/core/hec_pkg.sv @@
package hec_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] X_CHAR    = 8'h78;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;

	// register indexes
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_EVERY = 1'b1;

	localparam logic MODE_ESCAPE   = 1'b0;
	localparam logic MODE_UNESCAPE = 1'b1;

	typedef enum logic [1:0] {
		PH_BSL,
		PH_X,
		PH_HI,
		PH_LO
	} hec_phase_t;

	typedef struct packed {
		logic mode;
		logic every;
	} hec_cfg_t;

	// one decision: a byte sent as is, or as a four-byte escape
	typedef struct packed {
		logic       final_b;
		logic       esc;
		logic [7:0] data;
	} hec_cmd_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h57 + {4'd0, v};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/hec_front.sv @@
module hec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  hec_pkg::hec_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_final,
	input  logic              q_ready,
	output logic              q_push,
	output hec_pkg::hec_cmd_t q_cmd
);
	import hec_pkg::*;

	logic [7:0] w_q [4];
	logic [2:0] n_q;
	logic       flush_q;

	logic [7:0] cw [4];
	logic [7:0] nw [4];
	logic [2:0] cn;
	logic [2:0] rem;
	logic       cfin;
	logic       accept;
	logic       decide;
	logic       seq;
	logic       used4;
	logic [4:0] h2;
	logic [4:0] h3;

	assign in_ready = !flush_q && q_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cw[i] = w_q[i];
		end
		if (!flush_q) begin
			cw[n_q[1:0]] = in_byte;
		end
		cn   = flush_q ? n_q : n_q + 3'd1;
		cfin = flush_q || in_final;
		h2   = hex_val(cw[2]);
		h3   = hex_val(cw[3]);
		seq  = (cn == 3'd4) && (cw[0] == BACKSLASH) && (cw[1] == X_CHAR) && !h2[4] && !h3[4];

		q_cmd.esc  = 1'b0;
		q_cmd.data = cw[0];
		used4      = 1'b0;
		if (cfg.mode == MODE_ESCAPE) begin
			q_cmd.esc = cfg.every || (cw[0] < PRINT_LO) || (cw[0] > PRINT_HI) || seq;
		end else if (seq) begin
			q_cmd.data = {h2[3:0], h3[3:0]};
			used4      = 1'b1;
		end
		rem           = used4 ? 3'd0 : cn - 3'd1;
		q_cmd.final_b = cfin && (rem == 3'd0);

		for (int i = 0; i < 3; i++) begin
			nw[i] = cw[i + 1];
		end
		nw[3] = 8'h00;

		decide = cfin || (cn == 3'd4);
		q_push = (flush_q ? q_ready : accept) && decide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= 8'h00;
			end
			n_q     <= 3'd0;
			flush_q <= 1'b0;
		end else if (flush_q) begin
			// drain one decision a cycle while the queue has room, until the window is empty
			if (q_ready) begin
				w_q <= nw;
				n_q <= rem;
				if (rem == 3'd0) begin
					flush_q <= 1'b0;
				end
			end
		end else if (accept) begin
			if (decide) begin
				w_q     <= nw;
				n_q     <= rem;
				flush_q <= cfin && (rem != 3'd0);
			end else begin
				w_q <= cw;
				n_q <= cn;
			end
		end
	end

endmodule

@@ rtl/core/hec_queue.sv @@
module hec_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hec_pkg::hec_cmd_t push_cmd,
	output logic              not_full,
	input  logic              pop,
	output logic              not_empty,
	output hec_pkg::hec_cmd_t pop_cmd
);
	import hec_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hec_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign not_full  = (cnt_q != CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/core/hec_back.sv @@
module hec_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  hec_pkg::hec_cmd_t q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_final
);
	import hec_pkg::*;

	hec_cmd_t   cur_q;
	logic       cur_v_q;
	hec_phase_t ph_q;
	logic       m_valid_q;
	logic [7:0] m_byte_q;
	logic       m_final_q;

	logic       load;
	logic       last;
	logic [7:0] nxt_byte;

	assign load  = cur_v_q && (!m_valid_q || out_ready);
	assign last  = !cur_q.esc || (ph_q == PH_LO);
	assign q_pop = q_valid && (!cur_v_q || (load && last));

	assign out_valid = m_valid_q;
	assign out_byte  = m_byte_q;
	assign out_final = m_final_q;

	always_comb begin
		nxt_byte = cur_q.data;
		if (cur_q.esc) begin
			unique case (ph_q)
				PH_BSL:  nxt_byte = BACKSLASH;
				PH_X:    nxt_byte = X_CHAR;
				PH_HI:   nxt_byte = hex_char(cur_q.data[7:4]);
				PH_LO:   nxt_byte = hex_char(cur_q.data[3:0]);
				default: nxt_byte = cur_q.data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_byte_q  <= nxt_byte;
			m_final_q <= cur_q.final_b && last;
		end
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			cur_v_q   <= 1'b0;
			ph_q      <= PH_BSL;
		end else begin
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_v_q <= 1'b1;
				ph_q    <= PH_BSL;
			end else if (load) begin
				ph_q <= last ? PH_BSL : hec_phase_t'(ph_q + 2'd1);
				if (last) begin
					cur_v_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ rtl/core/hex_escape_codec.sv @@
// Once the lookahead window holds three earlier bytes (or the byte is final), a decision
// goes to the queue, then the command and output registers. The back end sends one byte
// per cycle unless m_tready stalls it; an escaped byte becomes four, a plain or decoded
// byte one. A final byte drains the window, one decision per cycle if the queue has room.
// Reset (arst_n low, asynchronous): window, queue and output empty, escape mode selected.
module hex_escape_codec #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // out_final
);
	import hec_pkg::*;

	hec_cfg_t cfg_q;
	hec_cmd_t push_cmd;
	hec_cmd_t pop_cmd;
	logic     push;
	logic     not_full;
	logic     pop;
	logic     not_empty;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_ESCAPE;
			cfg_q.every <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MODE:  cfg_q.mode  <= pwdata[0];
				REG_EVERY: cfg_q.every <= pwdata[0];
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:  prdata = {31'd0, cfg_q.mode};
			REG_EVERY: prdata = {31'd0, cfg_q.every};
			default:   prdata = 32'd0;
		endcase
	end

	hec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_final (s_tlast),
		.q_ready  (not_full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	hec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_cmd   (pop_cmd)
	);

	hec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_final (m_tlast)
	);

endmodule

@@ rtl/core/hec_checker.sv @@
module hec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);
	import hec_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_rd_upper: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[31:1] == 31'd0)
		else $error("unused register bits read nonzero");

	// a write shows up on a read of the same register in the next cycle
	a_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=>
		!(psel && !pwrite && (paddr[2] == $past(paddr[2]))) ||
		(prdata[0] == $past(pwdata[0])))
		else $error("register read does not return written value");

endmodule

bind hex_escape_codec hec_checker u_hec_checker (.*);
